// ===== hdl/nsc_pkg.sv =====
// Shared constants and helper functions for the NMEA sentence checker.
`default_nettype none
package nsc_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  localparam logic [2:0] TYPE_LEN = 3'd5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam logic [39:0] TYPE_GGA = 40'h4750474741; // GPGGA
  localparam logic [39:0] TYPE_GSA = 40'h4750475341; // GPGSA
  localparam logic [39:0] TYPE_GSV = 40'h4750475356; // GPGSV
  localparam logic [39:0] TYPE_RMC = 40'h4750524D43; // GPRMC

  localparam logic [1:0] CODE_GGA = 2'd0;
  localparam logic [1:0] CODE_GSA = 2'd1;
  localparam logic [1:0] CODE_GSV = 2'd2;
  localparam logic [1:0] CODE_RMC = 2'd3;

  typedef logic [3:0][7:0] type_prefix_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] code;
  } type_match_t;

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'd0, v};
    end else begin
      r = CH_UPPER_A + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

  // First four gathered characters plus the fifth against the known types.
  function automatic type_match_t match_type(input type_prefix_t pre, input logic [7:0] c);
    logic [39:0] word;
    type_match_t m;
    word = {pre[0], pre[1], pre[2], pre[3], c};
    m.hit = 1'b1;
    priority if (word == TYPE_GGA) begin
      m.code = CODE_GGA;
    end else if (word == TYPE_GSA) begin
      m.code = CODE_GSA;
    end else if (word == TYPE_GSV) begin
      m.code = CODE_GSV;
    end else if (word == TYPE_RMC) begin
      m.code = CODE_RMC;
    end else begin
      m.hit = 1'b0;
      m.code = CODE_GGA;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/nmea_sentence_checker_core.sv =====
// Top level of the NMEA sentence checker: character parser and verdict register.
//
// One request per received character, one result per request. Each character
// is decoded combinationally against the parser state and the result is held
// in an output register, so a new character is taken every cycle as long as
// the result register is empty or being drained in that same cycle; the rate
// is one character per clock, set only by the downstream ready.
`default_nettype none
module nmea_sentence_checker_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            payload_valid,
  output logic [7:0]      payload_char,
  output logic [1:0]      sentence_type,
  output logic            sentence_done,
  output logic            checksum_ok,
  output logic            sentence_abort
);

  logic [1:0]            parse_phase, parse_phase_next;
  nsc_pkg::type_prefix_t type_chars, type_chars_next;
  logic [2:0]            type_count, type_count_next;
  logic [7:0]            running_xor, running_xor_next;
  logic [1:0]            matched_type, matched_type_next;
  logic [7:0]            first_hex_char, first_hex_char_next;
  logic                  hex_count, hex_count_next;

  logic                  pv, done, ok, ab;
  logic [7:0]            pc;
  logic [1:0]            st;
  logic [7:0]            xor_in;
  nsc_pkg::type_match_t  tm;
  logic                  fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign xor_in   = running_xor ^ rx_char;
  assign tm       = nsc_pkg::match_type(type_chars, rx_char);

  always_comb begin
    parse_phase_next    = parse_phase;
    type_chars_next     = type_chars;
    type_count_next     = type_count;
    running_xor_next    = running_xor;
    matched_type_next   = matched_type;
    first_hex_char_next = first_hex_char;
    hex_count_next      = hex_count;
    pv   = 1'b0;
    pc   = 8'd0;
    st   = 2'd0;
    done = 1'b0;
    ok   = 1'b0;
    ab   = 1'b0;
    unique case (parse_phase)
      nsc_pkg::PH_IDLE: begin
        if (rx_char == nsc_pkg::CH_DOLLAR) begin
          running_xor_next = 8'd0;
          type_count_next  = 3'd0;
          parse_phase_next = nsc_pkg::PH_TYPE;
        end
      end
      nsc_pkg::PH_TYPE: begin
        running_xor_next = xor_in;
        if (type_count < nsc_pkg::TYPE_LEN) begin
          type_count_next = type_count + 3'd1;
        end
        if (type_count < (nsc_pkg::TYPE_LEN - 3'd1)) begin
          type_chars_next[type_count[1:0]] = rx_char;
        end
        if ((type_count == (nsc_pkg::TYPE_LEN - 3'd1)) && tm.hit) begin
          matched_type_next = tm.code;
          type_count_next   = 3'd0;
          parse_phase_next  = nsc_pkg::PH_BODY;
        end else if (rx_char == nsc_pkg::CH_COMMA) begin
          type_count_next  = 3'd0;
          running_xor_next = 8'd0;
          parse_phase_next = nsc_pkg::PH_IDLE;
        end
      end
      nsc_pkg::PH_BODY: begin
        if (rx_char == nsc_pkg::CH_STAR) begin
          hex_count_next   = 1'b0;
          parse_phase_next = nsc_pkg::PH_HEX;
        end else if (rx_char == nsc_pkg::CH_DOLLAR) begin
          ab               = 1'b1;
          running_xor_next = 8'd0;
          type_count_next  = 3'd0;
          parse_phase_next = nsc_pkg::PH_TYPE;
        end else begin
          running_xor_next = xor_in;
          pv = 1'b1;
          pc = rx_char;
          st = matched_type;
        end
      end
      nsc_pkg::PH_HEX: begin
        if (!hex_count) begin
          first_hex_char_next = rx_char;
          hex_count_next      = 1'b1;
        end else begin
          done = 1'b1;
          st   = matched_type;
          ok   = (first_hex_char == nsc_pkg::hex_digit(running_xor[7:4])) &&
                 (rx_char == nsc_pkg::hex_digit(running_xor[3:0]));
          hex_count_next   = 1'b0;
          running_xor_next = 8'd0;
          parse_phase_next = nsc_pkg::PH_IDLE;
        end
      end
      default: begin
        parse_phase_next = nsc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= nsc_pkg::PH_IDLE;
      type_chars     <= '0;
      type_count     <= 3'd0;
      running_xor    <= 8'd0;
      matched_type   <= 2'd0;
      first_hex_char <= 8'd0;
      hex_count      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        parse_phase    <= parse_phase_next;
        type_chars     <= type_chars_next;
        type_count     <= type_count_next;
        running_xor    <= running_xor_next;
        matched_type   <= matched_type_next;
        first_hex_char <= first_hex_char_next;
        hex_count      <= hex_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      payload_valid  <= pv;
      payload_char   <= pc;
      sentence_type  <= st;
      sentence_done  <= done;
      checksum_ok    <= ok;
      sentence_abort <= ab;
    end
  end

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((payload_valid && sentence_done) || (payload_valid && sentence_abort) ||
                    (sentence_done && sentence_abort)))
    else $error("more than one event in a result");

  a_ok_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && checksum_ok) |-> sentence_done)
    else $error("checksum_ok without sentence_done");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_done_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && parse_phase == nsc_pkg::PH_HEX && hex_count) |=> (parse_phase == nsc_pkg::PH_IDLE))
    else $error("verdict did not return parser to idle");

endmodule
`default_nettype wire
